[rtl/ip_l4_checksum_engine_macros.svh]
// Assertion macros for the L4 checksum engine.
`ifndef IP_L4_CHECKSUM_ENGINE_MACROS_SVH
`define IP_L4_CHECKSUM_ENGINE_MACROS_SVH

// Check that cond holds in the same cycle as trig.
`define IPCS_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("checksum engine assertion failed");

// Check that cond holds in the cycle after trig.
`define IPCS_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("checksum engine assertion failed");

`endif

[rtl/ipcs_pkg.sv]
// Shared types, constants and helpers of the L4 checksum engine.
package ipcs_pkg;

    localparam int WORD_W = 16;
    localparam int IDX_W  = 15;
    localparam int HW_W   = 5;

    localparam logic [WORD_W-1:0] PROTO_UDP   = 16'd17;
    localparam logic [WORD_W-1:0] PROTO_TCP   = 16'd6;
    localparam logic [WORD_W-1:0] HIGH_MASK   = 16'hFF00;
    localparam logic [HW_W-1:0]   HDR_MIN     = 5'd5;
    localparam logic [IDX_W-1:0]  IP_CSUM_IDX = 15'd5;
    localparam logic [IDX_W-1:0]  ADDR_FIRST  = 15'd6;
    localparam logic [IDX_W-1:0]  ADDR_LAST   = 15'd9;
    localparam logic [IDX_W-1:0]  TLEN_IDX    = 15'd1;
    localparam logic [IDX_W-1:0]  INDEX_MAX   = 15'h7FFF;

    typedef enum logic [1:0] {
        KIND_IP   = 2'd0,
        KIND_UDP  = 2'd1,
        KIND_TCP  = 2'd2,
        KIND_ICMP = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [WORD_W-1:0] word;
        logic              last;
    } t_word;

    typedef struct packed {
        logic [WORD_W-1:0] checksum;
        logic              truncated;
        t_kind             kind_done;
    } t_result;

    function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
        logic [WORD_W:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, t[WORD_W]};
    endfunction

endpackage

[rtl/ipcs_in_reg.sv]
// Input register of the L4 checksum engine.
module ipcs_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ipcs_pkg::t_word i_item,
    output logic           o_valid,
    output ipcs_pkg::t_word o_item,
    input  logic           i_take
);
    import ipcs_pkg::*;

    logic  r_valid;
    t_word r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

[rtl/ipcs_calc.sv]
// Per-word checksum state update and end-of-packet result logic.
`include "ip_l4_checksum_engine_macros.svh"
module ipcs_calc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ipcs_pkg::t_word   i_item,
    input  logic              i_out_free,
    output logic              o_take,
    output logic              o_res_valid,
    output ipcs_pkg::t_result o_res
);
    import ipcs_pkg::*;

    logic [WORD_W-1:0] r_sum;
    logic [IDX_W-1:0]  r_word_index;
    logic [HW_W-1:0]   r_header_words;
    logic [WORD_W-1:0] r_l4_length;
    t_kind             r_kind;
    logic              r_index_full;

    t_kind             c_kind;
    logic [HW_W-1:0]   c_hw;
    logic [WORD_W-1:0] c_sum;
    logic [WORD_W-1:0] n_sum;
    logic [WORD_W-1:0] n_l4_length;
    logic [WORD_W-1:0] pre_sum;
    logic [WORD_W-1:0] w;
    logic [IDX_W-1:0]  idx;
    logic [5:0]        s;
    logic [6:0]        hdr_octets;
    logic [IDX_W-1:0]  off;
    logic [WORD_W-1:0] ext;
    logic [WORD_W:0]   off2;
    logic              whole;
    logic              half;
    logic [WORD_W-1:0] e_sum;
    logic [WORD_W-1:0] e_l4;
    logic [HW_W-1:0]   e_hw;
    t_kind             e_kind;
    logic [5:0]        e_s;
    logic [WORD_W:0]   n_cnt;
    logic [WORD_W:0]   req;
    logic [WORD_W-1:0] e_ext;
    logic              trunc;

    assign o_take      = i_valid && (!i_item.last || i_out_free);
    assign o_res_valid = o_take && i_item.last;

    always_comb begin
        w   = i_item.word;
        idx = r_word_index;
        if (idx == '0) begin
            c_kind = i_item.kind;
            c_hw   = (w[11:8] < HDR_MIN[3:0]) ? HDR_MIN : {1'b0, w[11:8]};
            c_sum  = '0;
            n_l4_length = '0;
        end else begin
            c_kind = r_kind;
            c_hw   = r_header_words;
            c_sum  = r_sum;
            n_l4_length = r_l4_length;
        end
        s          = {c_hw, 1'b0};
        hdr_octets = {c_hw, 2'b00};
        pre_sum    = c_sum;

        if (idx == TLEN_IDX && (c_kind == KIND_TCP || c_kind == KIND_ICMP)) begin
            n_l4_length = (w >= {9'd0, hdr_octets}) ? (w - {9'd0, hdr_octets}) : '0;
        end
        if (idx == TLEN_IDX && c_kind == KIND_TCP) begin
            pre_sum = oc_add(oc_add(c_sum, PROTO_TCP), n_l4_length);
        end else if ((c_kind == KIND_UDP || c_kind == KIND_TCP)
                     && idx >= ADDR_FIRST && idx <= ADDR_LAST) begin
            pre_sum = oc_add(c_sum, w);
        end else if (c_kind == KIND_UDP && idx == ({9'd0, s} + 15'd2)) begin
            n_l4_length = w;
            pre_sum = oc_add(oc_add(c_sum, PROTO_UDP), w);
        end

        off  = idx - {9'd0, s};
        off2 = {1'b0, off, 1'b0};
        ext  = n_l4_length;
        if (c_kind == KIND_UDP && ext < 16'd4) begin
            ext = 16'd4;
        end
        if (c_kind == KIND_UDP && off < 15'd2) begin
            whole = 1'b1;
            half  = 1'b0;
        end else begin
            whole = (off2 + 17'd2) <= {1'b0, ext};
            half  = (off2 + 17'd1) == {1'b0, ext};
        end

        n_sum = pre_sum;
        if (c_kind == KIND_IP) begin
            if (idx < {9'd0, s} && idx != IP_CSUM_IDX) begin
                n_sum = oc_add(pre_sum, w);
            end
        end else if (idx >= {9'd0, s}) begin
            if (whole) begin
                if (!(c_kind == KIND_ICMP && off == 15'd1)) begin
                    n_sum = oc_add(pre_sum, w);
                end
            end else if (half) begin
                n_sum = oc_add(pre_sum, w & HIGH_MASK);
            end
        end

        if (r_index_full) begin
            e_sum  = r_sum;
            e_l4   = r_l4_length;
            e_hw   = r_header_words;
            e_kind = r_kind;
            n_cnt  = 17'h08000;
        end else begin
            e_sum  = n_sum;
            e_l4   = n_l4_length;
            e_hw   = c_hw;
            e_kind = c_kind;
            n_cnt  = {2'b00, idx} + 17'd1;
        end
        e_s   = {e_hw, 1'b0};
        e_ext = e_l4;
        if (e_kind == KIND_UDP && e_ext < 16'd4) begin
            e_ext = 16'd4;
        end
        req = {11'd0, e_s} + (({1'b0, e_ext} + 17'd1) >> 1);
        unique case (e_kind)
            KIND_IP:  trunc = n_cnt < {11'd0, e_s};
            KIND_UDP: trunc = (n_cnt < ({11'd0, e_s} + 17'd3)) || (n_cnt < req);
            default:  trunc = (n_cnt < 17'd2) || (n_cnt < req);
        endcase

        o_res.checksum  = ~e_sum;
        o_res.truncated = trunc;
        o_res.kind_done = e_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum          <= '0;
            r_word_index   <= '0;
            r_header_words <= '0;
            r_l4_length    <= '0;
            r_kind         <= KIND_IP;
            r_index_full   <= 1'b0;
        end else if (o_take) begin
            if (!r_index_full) begin
                r_sum          <= n_sum;
                r_header_words <= c_hw;
                r_l4_length    <= n_l4_length;
                r_kind         <= c_kind;
            end
            if (i_item.last) begin
                r_word_index <= '0;
                r_index_full <= 1'b0;
            end else if (!r_index_full) begin
                if (idx == INDEX_MAX) begin
                    r_index_full <= 1'b1;
                end else begin
                    r_word_index <= idx + 15'd1;
                end
            end
        end
    end

    `IPCS_ASSERT_NEXT(a_last_rewinds, o_take && i_item.last, r_word_index == '0 && !r_index_full)
    `IPCS_ASSERT_SAME(a_full_at_max, r_index_full, r_word_index == INDEX_MAX)
    `IPCS_ASSERT_SAME(a_hdr_min, r_word_index != '0, r_header_words >= HDR_MIN)
    `IPCS_ASSERT_SAME(a_result_on_last, o_res_valid, o_take && i_item.last)

endmodule

[rtl/ip_l4_checksum_engine.sv]
// Top level of the IPv4 header / UDP / TCP / ICMP streaming checksum engine.
// Throughput: one packet word per cycle, including packet boundaries, while the output is not stalled.
// Result path: the last word passes the input register, then the result is computed from the
// checksum state and registered in the output result register, with the state update.
// Output stalls back-pressure the input only on a last word while the result is held.
// Reset: synchronous, active low; clears all valids, the running sum and word counters.
module ip_l4_checksum_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] packet_word
    input  logic        s_axis_tlast,   // last_word
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] checksum
    output logic [2:0]  m_axis_tuser    // [0] truncated, [2:1] kind_done
);
    import ipcs_pkg::*;

    t_word   in_item;
    t_word   st_item;
    logic    st_valid;
    logic    take;
    logic    out_free;
    logic    res_valid;
    t_result res;

    logic    r_m_valid;
    t_result r_m_res;

    assign in_item.kind = t_kind'(s_axis_tuser);
    assign in_item.word = s_axis_tdata;
    assign in_item.last = s_axis_tlast;

    ipcs_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (st_valid),
        .o_item  (st_item),
        .i_take  (take)
    );

    assign out_free = !r_m_valid || m_axis_tready;

    ipcs_calc u_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (st_valid),
        .i_item      (st_item),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_free) begin
            r_m_valid <= res_valid;
        end
        if (res_valid) begin
            r_m_res <= res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_res.checksum;
    assign m_axis_tuser  = {r_m_res.kind_done, r_m_res.truncated};

endmodule

[test/ip_l4_checksum_engine_test.sv]
// Self-checking stream testbench for the IPv4 header / UDP / TCP / ICMP checksum engine.
module ip_l4_checksum_engine_test;
    import ipcs_pkg::*;

    localparam int UDP_LEN_OFF   = 2;
    localparam int ICMP_CSUM_OFF = 1;
    localparam int UDP_MIN_EXT   = 4;
    localparam int GAP_MAX       = 14;
    localparam int RAND_WORDS    = 800;
    localparam int DIR_ROWS      = 25;
    localparam int DRAIN_CYCLES  = 10;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        t_kind       act;
        logic [15:0] word;
        logic        last;
        logic        typed;
        t_result     want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    logic [15:0] acc_sum;
    logic [14:0] word_pos;
    logic [4:0]  ihl_words;
    logic [15:0] total_len;
    logic [15:0] l4_len;
    t_kind       cur_kind;
    logic        pos_saturated;

    t_result expected_sums[$];
    t_row    dir_rows[DIR_ROWS];

    int send_gap_max;
    int recv_gap_max;
    int fail_count;
    int words_sent;
    int packets_sent;
    int results_due;
    int results_seen;
    int trunc_seen;

    ip_l4_checksum_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        int unsigned t;
        t = a + b;
        t = (t & 32'hFFFF) + (t >> 16);
        return t[15:0];
    endfunction

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("ERROR: %s", msg);
        end
    endtask

    task automatic absorb_word(input t_kind act, input logic [15:0] w, input logic last,
                               output logic produced, output t_result res);
        int unsigned idx, s, hdr_oct, off, ext, n, need;
        logic whole, half, trunc;
        idx      = word_pos;
        produced = 1'b0;
        res      = '0;
        if (!pos_saturated) begin
            if (idx == 0) begin
                cur_kind  = act;
                acc_sum   = '0;
                total_len = '0;
                l4_len    = '0;
                ihl_words = (w[11:8] < HDR_MIN) ? HDR_MIN : {1'b0, w[11:8]};
            end
            s       = 2 * ihl_words;
            hdr_oct = 4 * ihl_words;
            if (idx == TLEN_IDX) begin
                total_len = w;
                if (cur_kind == KIND_TCP || cur_kind == KIND_ICMP) begin
                    l4_len = (w >= hdr_oct) ? 16'(w - hdr_oct) : 16'd0;
                end
                if (cur_kind == KIND_TCP) begin
                    acc_sum = ones_add(ones_add(acc_sum, PROTO_TCP), l4_len);
                end
            end
            if ((cur_kind == KIND_UDP || cur_kind == KIND_TCP) &&
                idx >= ADDR_FIRST && idx <= ADDR_LAST) begin
                acc_sum = ones_add(acc_sum, w);
            end
            if (cur_kind == KIND_UDP && idx == s + UDP_LEN_OFF) begin
                l4_len  = w;
                acc_sum = ones_add(ones_add(acc_sum, PROTO_UDP), w);
            end
            if (cur_kind == KIND_IP) begin
                if (idx < s && idx != IP_CSUM_IDX) begin
                    acc_sum = ones_add(acc_sum, w);
                end
            end else if (idx >= s) begin
                off = idx - s;
                if (cur_kind == KIND_UDP && off < UDP_LEN_OFF) begin
                    whole = 1'b1;
                    half  = 1'b0;
                end else begin
                    ext = l4_len;
                    if (cur_kind == KIND_UDP && ext < UDP_MIN_EXT) begin
                        ext = UDP_MIN_EXT;
                    end
                    whole = (2 * off + 2 <= ext);
                    half  = (2 * off + 1 == ext);
                end
                if (whole) begin
                    if (!(cur_kind == KIND_ICMP && off == ICMP_CSUM_OFF)) begin
                        acc_sum = ones_add(acc_sum, w);
                    end
                end else if (half) begin
                    acc_sum = ones_add(acc_sum, w & HIGH_MASK);
                end
            end
        end
        if (!last) begin
            if (!pos_saturated) begin
                if (idx >= INDEX_MAX) begin
                    pos_saturated = 1'b1;
                end else begin
                    word_pos = 15'(idx + 1);
                end
            end
        end else begin
            s = 2 * ihl_words;
            n = pos_saturated ? int'(INDEX_MAX) + 1 : idx + 1;
            if (cur_kind == KIND_IP) begin
                trunc = (n < s);
            end else if (cur_kind == KIND_UDP) begin
                if (n < s + UDP_LEN_OFF + 1) begin
                    trunc = 1'b1;
                end else begin
                    ext   = (l4_len < UDP_MIN_EXT) ? UDP_MIN_EXT : l4_len;
                    need  = s + (ext + 1) / 2;
                    trunc = (n < need);
                end
            end else begin
                if (n < TLEN_IDX + 1) begin
                    trunc = 1'b1;
                end else begin
                    need  = s + (l4_len + 1) / 2;
                    trunc = (n < need);
                end
            end
            res.checksum  = ~acc_sum;
            res.truncated = trunc;
            res.kind_done = cur_kind;
            produced      = 1'b1;
            word_pos      = '0;
            pos_saturated = 1'b0;
        end
    endtask

    task automatic send_word(input t_kind act, input logic [15:0] w, input logic last,
                             input logic use_typed, input t_result typed_res);
        int gap;
        logic produced;
        t_result res;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tlast  <= last;
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        absorb_word(act, w, last, produced, res);
        words_sent++;
        if (produced) begin
            expected_sums.push_back(use_typed ? typed_res : res);
            results_due++;
        end
        @(negedge i_clk);
    endtask

    task automatic random_packet(input bit huge);
        t_kind k;
        int hl_raw, hw, l4, udp_len, nw, i;
        bit noise;
        logic [15:0] tot, w;
        k       = t_kind'($urandom_range(0, 3));
        hl_raw  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
        hw      = (hl_raw < HDR_MIN) ? HDR_MIN : hl_raw;
        l4      = huge ? 65535 - 4 * hw : $urandom_range(0, 60);
        tot     = 16'(4 * hw + l4);
        udp_len = (!huge && $urandom_range(0, 4) == 0) ? $urandom_range(0, 70) : l4;
        if (k == KIND_IP) begin
            nw = 2 * hw;
        end else if (k == KIND_UDP) begin
            nw = 2 * hw + (((udp_len < UDP_MIN_EXT) ? UDP_MIN_EXT : udp_len) + 1) / 2;
            if (nw < 2 * hw + UDP_LEN_OFF + 1) begin
                nw = 2 * hw + UDP_LEN_OFF + 1;
            end
        end else begin
            nw = 2 * hw + (l4 + 1) / 2;
        end
        noise = 1'b0;
        if (huge) begin
            nw = int'(INDEX_MAX) + 1 + $urandom_range(0, 3);
        end else begin
            case ($urandom_range(0, 9))
                0: nw = nw + $urandom_range(1, 3);
                1: nw = $urandom_range(1, nw - 1);
                2: tot = 16'($urandom_range(0, 65535));
                3: begin
                    noise = 1'b1;
                    nw    = $urandom_range(1, 24);
                end
                default: ;
            endcase
        end
        for (i = 0; i < nw; i++) begin
            w = 16'($urandom_range(0, 65535));
            if (!noise) begin
                if (i == 0) begin
                    w[15:8] = {4'h4, 4'(hl_raw)};
                end
                if (i == 1) begin
                    w = tot;
                end
                if (k == KIND_UDP && i == 2 * hw + UDP_LEN_OFF) begin
                    w = 16'(udp_len);
                end
            end
            send_word((i == 0) ? k : t_kind'($urandom_range(0, 3)), w, i == nw - 1, 1'b0, '0);
        end
        packets_sent++;
    endtask

    initial begin
        int r;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = '0;
        i_rst_n       = 1'b0;
        acc_sum       = '0;
        word_pos      = '0;
        ihl_words     = '0;
        total_len     = '0;
        l4_len        = '0;
        cur_kind      = KIND_IP;
        pos_saturated = 1'b0;
        send_gap_max  = GAP_MAX;
        recv_gap_max  = GAP_MAX;
        fail_count    = 0;
        words_sent    = 0;
        packets_sent  = 0;
        results_due   = 0;
        results_seen  = 0;
        trunc_seen    = 0;

        dir_rows[0]  = '{KIND_IP,   16'h0000, 1'b1, 1'b1, '{16'hFFFF, 1'b1, KIND_IP}};
        dir_rows[1]  = '{KIND_ICMP, 16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 1'b1, KIND_ICMP}};
        dir_rows[2]  = '{KIND_UDP,  16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 1'b1, KIND_UDP}};
        dir_rows[3]  = '{KIND_TCP,  16'h0000, 1'b1, 1'b1, '{16'hFFFF, 1'b1, KIND_TCP}};
        dir_rows[4]  = '{KIND_IP,   16'h45FF, 1'b0, 1'b0, '0};
        dir_rows[5]  = '{KIND_ICMP, 16'h0014, 1'b0, 1'b0, '0};
        dir_rows[6]  = '{KIND_UDP,  16'hFFFF, 1'b0, 1'b0, '0};
        dir_rows[7]  = '{KIND_TCP,  16'h0000, 1'b0, 1'b0, '0};
        dir_rows[8]  = '{KIND_ICMP, 16'h4006, 1'b0, 1'b0, '0};
        dir_rows[9]  = '{KIND_UDP,  16'hBEEF, 1'b0, 1'b0, '0};
        dir_rows[10] = '{KIND_TCP,  16'hC0A8, 1'b0, 1'b0, '0};
        dir_rows[11] = '{KIND_ICMP, 16'h0001, 1'b0, 1'b0, '0};
        dir_rows[12] = '{KIND_UDP,  16'hC0A8, 1'b0, 1'b0, '0};
        dir_rows[13] = '{KIND_TCP,  16'h00C7, 1'b1, 1'b0, '0};
        dir_rows[14] = '{KIND_TCP,  16'h4500, 1'b0, 1'b0, '0};
        dir_rows[15] = '{KIND_IP,   16'h0015, 1'b0, 1'b0, '0};
        dir_rows[16] = '{KIND_UDP,  16'h0000, 1'b0, 1'b0, '0};
        dir_rows[17] = '{KIND_ICMP, 16'h0000, 1'b0, 1'b0, '0};
        dir_rows[18] = '{KIND_IP,   16'h4006, 1'b0, 1'b0, '0};
        dir_rows[19] = '{KIND_UDP,  16'h0000, 1'b0, 1'b0, '0};
        dir_rows[20] = '{KIND_ICMP, 16'h0A00, 1'b0, 1'b0, '0};
        dir_rows[21] = '{KIND_IP,   16'h0001, 1'b0, 1'b0, '0};
        dir_rows[22] = '{KIND_UDP,  16'h0A00, 1'b0, 1'b0, '0};
        dir_rows[23] = '{KIND_ICMP, 16'h0002, 1'b0, 1'b0, '0};
        dir_rows[24] = '{KIND_IP,   16'hABCD, 1'b1, 1'b0, '0};

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (r = 0; r < DIR_ROWS; r++) begin
            send_word(dir_rows[r].act, dir_rows[r].word, dir_rows[r].last,
                      dir_rows[r].typed, dir_rows[r].want);
        end
        packets_sent = 6;

        while (words_sent < DIR_ROWS + RAND_WORDS) begin
            send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
            recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
            random_packet(1'b0);
        end
        s_axis_tvalid <= 1'b0;

        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words in %0d packets of all four kinds, with short and odd lengths.",
                 words_sent, packets_sent);
        $display("Checked %0d results (%0d truncated), %0d mismatches.",
                 results_seen, trunc_seen, fail_count);
        if (fail_count == 0 && expected_sums.size() == 0) begin
            $display("ip_l4_checksum_engine_test: PASS");
        end else begin
            $display("ip_l4_checksum_engine_test: FAIL");
        end
        $finish;
    end

    initial begin
        int stall;
        t_result want;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = $urandom_range(0, recv_gap_max);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            results_seen++;
            if (m_axis_tuser[0]) begin
                trunc_seen++;
            end
            if (expected_sums.size() == 0) begin
                flag_error($sformatf("unexpected result: checksum %h truncated %b kind %0d",
                                     m_axis_tdata, m_axis_tuser[0], m_axis_tuser[2:1]));
            end else begin
                want = expected_sums.pop_front();
                if (m_axis_tdata !== want.checksum) begin
                    flag_error($sformatf("checksum: expected %h, got %h",
                                         want.checksum, m_axis_tdata));
                end
                if (m_axis_tuser[0] !== want.truncated) begin
                    flag_error($sformatf("truncated: expected %b, got %b",
                                         want.truncated, m_axis_tuser[0]));
                end
                if (m_axis_tuser[2:1] !== want.kind_done) begin
                    flag_error($sformatf("kind: expected %0d, got %0d",
                                         want.kind_done, m_axis_tuser[2:1]));
                end
            end
            @(negedge i_clk);
        end
    end

    initial begin
        #10_000_000;
        $display("ip_l4_checksum_engine_test: FAIL");
        $finish;
    end

endmodule
